// ===== rtl/core/base64_encoder_macros.svh =====
// Assertion macros shared by the Base64 encoder RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
// No other dependencies.
`ifndef BASE64_ENCODER_MACROS_SVH
`define BASE64_ENCODER_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define B64E_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next.
`define B64E_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== rtl/core/b64e_pkg.sv =====
// Package for the Base64 encoder: request and result types, queue entry type,
// group phase encoding and the sextet-to-ASCII alphabet function.
// Used by every module of the encoder; it depends on nothing.
package b64e_pkg;

  // Input request: one raw message byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } in_t;

  // Result: one ASCII character of the encoded text.
  typedef struct packed {
    logic [6:0] code_char;
    logic       end_of_text;
  } out_t;

  localparam int unsigned CharW    = 7;
  localparam int unsigned MaxChars = 4;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [CharW-1:0] PadChar = 7'h3D;

  // One classified byte: up to four characters and the index of the last one.
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [1:0]                     last_idx;
    logic                           is_final;
  } job_t;

  // Position of the next byte within its three-byte group.
  typedef enum logic [2:0] {
    PH0 = 3'b001,
    PH1 = 3'b010,
    PH2 = 3'b100
  } phase_t;

  // Maps a sextet to its character in the standard alphabet.
  function automatic logic [CharW-1:0] sextet_char(input logic [5:0] v);
    logic [CharW-1:0] c;
    case (v) inside
      [6'd0:6'd25]:  c = {1'b0, v} + 7'd65;
      [6'd26:6'd51]: c = {1'b0, v} + 7'd71;
      [6'd52:6'd61]: c = {1'b0, v} - 7'd4;
      6'd62:         c = 7'h2B;
      default:       c = 7'h2F;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/b64e_front.sv =====
// Front end of the Base64 encoder: accepts byte requests, tracks the group
// phase and leftover bits, and turns each byte into a queue entry of characters.
// Depends on b64e_pkg and base64_encoder_macros.svh.
`include "base64_encoder_macros.svh"

module b64e_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  b64e_pkg::in_t   in_data,
  input  logic            q_full,
  output logic            q_push,
  output b64e_pkg::job_t  q_job
);

  b64e_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       left_r, left_nxt;
  logic [7:0]       b;
  logic             fin;

  assign b        = in_data.data_byte;
  assign fin      = in_data.is_final;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the byte by phase and build its characters.
  always_comb begin
    q_job          = '0;
    q_job.is_final = fin;
    phase_nxt      = phase_r;
    left_nxt       = left_r;
    case (phase_r)
      b64e_pkg::PH1: begin
        q_job.chars[0] = b64e_pkg::sextet_char({left_r[1:0], b[7:4]});
        if (fin) begin
          q_job.chars[1] = b64e_pkg::sextet_char({b[3:0], 2'b00});
          q_job.chars[2] = b64e_pkg::PadChar;
          q_job.last_idx = 2'd2;
          phase_nxt      = b64e_pkg::PH0;
          left_nxt       = '0;
        end else begin
          q_job.last_idx = 2'd0;
          phase_nxt      = b64e_pkg::PH2;
          left_nxt       = b[3:0];
        end
      end
      b64e_pkg::PH2: begin
        q_job.chars[0] = b64e_pkg::sextet_char({left_r, b[7:6]});
        q_job.chars[1] = b64e_pkg::sextet_char(b[5:0]);
        q_job.last_idx = 2'd1;
        phase_nxt      = b64e_pkg::PH0;
        left_nxt       = '0;
      end
      default: begin
        q_job.chars[0] = b64e_pkg::sextet_char(b[7:2]);
        if (fin) begin
          q_job.chars[1] = b64e_pkg::sextet_char({b[1:0], 4'b0000});
          q_job.chars[2] = b64e_pkg::PadChar;
          q_job.chars[3] = b64e_pkg::PadChar;
          q_job.last_idx = 2'd3;
          phase_nxt      = b64e_pkg::PH0;
          left_nxt       = '0;
        end else begin
          q_job.last_idx = 2'd0;
          phase_nxt      = b64e_pkg::PH1;
          left_nxt       = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  // Phase and leftover bits advance on every accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= b64e_pkg::PH0;
      left_r  <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

  `B64E_ASSERT_NEXT(a_final_restarts, q_push && fin, phase_r == b64e_pkg::PH0 && left_r == 4'd0, "Final byte did not return the encoder to the start of a group")
  `B64E_ASSERT(a_left_fits, phase_r != b64e_pkg::PH1 || left_r[3:2] == 2'b00, "More than two leftover bits after the first byte of a group")

endmodule

// ===== rtl/core/b64e_fifo.sv =====
// Short queue between the front and back ends of the Base64 encoder.
// Holds classified bytes in flip-flops; depends on b64e_pkg and the macro header.
`include "base64_encoder_macros.svh"

module b64e_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64e_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output b64e_pkg::job_t  head_job
);

  b64e_pkg::job_t                   mem_r [b64e_pkg::QDepth];
  logic [b64e_pkg::QPtrW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [b64e_pkg::QPtrW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [b64e_pkg::QCntW-1:0]       cnt_r, cnt_nxt;

  assign full     = (cnt_r == b64e_pkg::QCntW'(b64e_pkg::QDepth));
  assign empty    = (cnt_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `B64E_ASSERT(a_no_overflow, !(push && full), "Push into a full queue")
  `B64E_ASSERT(a_no_underflow, !(pop && empty), "Pop from an empty queue")
  `B64E_ASSERT(a_ptr_track, cnt_r == b64e_pkg::QCntW'(b64e_pkg::QDepth) || b64e_pkg::QPtrW'(wr_ptr_r - rd_ptr_r) == cnt_r[b64e_pkg::QPtrW-1:0], "Fill count disagrees with pointers")

endmodule

// ===== rtl/core/b64e_back.sv =====
// Back end of the Base64 encoder: walks the characters of the queue head one per
// cycle into the output register unless stalled; uses b64e_pkg and the macro header.
`include "base64_encoder_macros.svh"

module b64e_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  b64e_pkg::job_t  q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output b64e_pkg::out_t  out_char
);

  logic [1:0]      idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  b64e_pkg::out_t  out_char_r;
  logic            load;
  logic            cur_last;

  // The output register takes a new character when empty or being drained.
  assign load     = !q_empty && (!out_valid_r || !out_stall);
  assign cur_last = (idx_r == q_head.last_idx);
  assign q_pop    = load && cur_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = cur_last ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Character payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r.code_char   <= q_head.chars[idx_r];
      out_char_r.end_of_text <= q_head.is_final && cur_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;

  `B64E_ASSERT(a_idx_bound, q_empty || idx_r <= q_head.last_idx, "Character index out of range")

endmodule

// ===== rtl/core/base64_encoder.sv =====
// Top level of the streaming Base64 encoder (standard alphabet, '=' padding).
// Instantiates b64e_front, b64e_fifo and b64e_back; types come from b64e_pkg.
//
// Usage: each input request carries one message byte and is_final, which marks
// the last byte of a message. Each result carries one ASCII character; the last
// character of a message (including padding) has end_of_text set. Both channels
// use valid and stall, and an item moves at a clock edge with valid high and
// stall low.
// Path: an accepted byte is written into the queue entry, and the output register
// then takes its characters one a cycle while the receiver does not stall.
// Throughput: the output register sends one character per cycle while the receiver
// does not stall. Within a message two bytes of each group yield one character
// and the third yields two, so a long message gives four characters per three
// bytes; a final byte yields up to four characters. A four-entry queue lets bytes
// enter one per cycle until it fills; in_stall is high while it is full.
// Reset (synchronous, rst_n low) empties the queue and output register and
// starts a new three-byte group. While the receiver stalls, the output
// character holds and the queue absorbs further bytes before in_stall rises.

module base64_encoder (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  b64e_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output b64e_pkg::out_t  out_char
);

  b64e_pkg::job_t  push_job;
  b64e_pkg::job_t  head_job;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (full),
    .q_push   (push),
    .q_job    (push_job)
  );

  b64e_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head_job (head_job)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (empty),
    .q_head    (head_job),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the streaming Base64 encoder base64_encoder.
// Depends on b64e_pkg for the request and result types and on the encoder RTL.
// A built-in predictor computes the expected characters and a monitor compares them in order.
module testbench;

  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned TIMEOUT      = 400000;
  localparam int unsigned SETTLE       = 30;
  localparam int unsigned RANDOM_TOTAL = 260;
  localparam int unsigned HOLD_LEN     = 80;
  localparam int unsigned HOLD_COUNT   = 2;

  // Position of the next byte within its three-byte group.
  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;

  localparam logic [6:0] PAD_ASCII = 7'h3D;
  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // One queued request; drain_first makes the sender wait until all results are in.
  typedef struct {
    b64e_pkg::in_t req;
    bit            drain_first;
  } byte_req_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  b64e_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  b64e_pkg::out_t out_char;

  byte_req_t      pending_bytes[$];
  b64e_pkg::out_t expected_chars[$];
  logic [1:0]     grp_slot = SLOT_FIRST;
  logic [3:0]     carry_bits = '0;
  int unsigned    total_bytes = 0;
  int unsigned    accepted_bytes = 0;
  int unsigned    mismatches = 0;
  int unsigned    cycle_count = 0;

  base64_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char)
  );

  // Clock generation.
  initial begin
    forever #1 clk = ~clk;
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT) begin
      $display("timeout after %0d cycles, %0d bytes accepted", cycle_count, accepted_bytes);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  function automatic logic [6:0] alphabet_char(input logic [5:0] sextet);
    return B64_ALPHABET[8 * (63 - int'(sextet)) +: 7];
  endfunction

  task automatic queue_char(input logic [6:0] ch, input logic last);
    b64e_pkg::out_t item;
    item.code_char   = ch;
    item.end_of_text = last;
    expected_chars.push_back(item);
  endtask

  // Predicts the characters that one accepted byte produces and advances the group.
  task automatic encode_byte(input b64e_pkg::in_t req);
    logic [7:0] b;
    b = req.data_byte;
    case (grp_slot)
      SLOT_SECOND: begin
        queue_char(alphabet_char({carry_bits[1:0], b[7:4]}), 1'b0);
        if (req.is_final) begin
          queue_char(alphabet_char({b[3:0], 2'b00}), 1'b0);
          queue_char(PAD_ASCII, 1'b1);
          grp_slot   = SLOT_FIRST;
          carry_bits = '0;
        end else begin
          carry_bits = b[3:0];
          grp_slot   = SLOT_THIRD;
        end
      end
      SLOT_THIRD: begin
        queue_char(alphabet_char({carry_bits, b[7:6]}), 1'b0);
        queue_char(alphabet_char(b[5:0]), req.is_final);
        grp_slot   = SLOT_FIRST;
        carry_bits = '0;
      end
      // The unused slot value behaves as the first slot.
      default: begin
        queue_char(alphabet_char(b[7:2]), 1'b0);
        if (req.is_final) begin
          queue_char(alphabet_char({b[1:0], 4'b0000}), 1'b0);
          queue_char(PAD_ASCII, 1'b0);
          queue_char(PAD_ASCII, 1'b1);
          grp_slot   = SLOT_FIRST;
          carry_bits = '0;
        end else begin
          carry_bits = {2'b00, b[1:0]};
          grp_slot   = SLOT_SECOND;
        end
      end
    endcase
  endtask

  task automatic check_char(input b64e_pkg::out_t got);
    b64e_pkg::out_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected character %h eot %b", got.code_char,
                                got.end_of_text));
      return;
    end
    want = expected_chars.pop_front();
    if (got.code_char !== want.code_char)
      report_mismatch($sformatf("code_char %h, expected %h", got.code_char, want.code_char));
    if (got.end_of_text !== want.end_of_text)
      report_mismatch($sformatf("end_of_text %b, expected %b", got.end_of_text,
                                want.end_of_text));
  endtask

  // Accepted requests feed the predictor; accepted results are checked in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      grp_slot   = SLOT_FIRST;
      carry_bits = '0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_byte(in_data);
        accepted_bytes++;
      end
      if (out_valid && !out_stall) check_char(out_char);
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin : drive
    int unsigned issued;
    int unsigned burst_left;
    int unsigned gap_left;
    bit          taken;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      issued     = 0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      taken = (accepted_bytes != issued);
      if (taken) begin
        void'(pending_bytes.pop_front());
        issued++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // Now and then a long burst without gaps.
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (in_valid && !taken) begin
        // The offered request holds until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_bytes[0].drain_first && expected_chars.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data  <= pending_bytes[0].req;
      end
    end
  end

  // Receiver: a stall pattern that steps through four modes, plus long hold-offs.
  always @(negedge clk) begin : receive
    int unsigned stall_cycle;
    int unsigned hold_left;
    int unsigned holds_done;
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_cycle = 0;
      hold_left   = 0;
      holds_done  = 0;
    end else begin
      stall_cycle++;
      if (holds_done < HOLD_COUNT && accepted_bytes >= 40 + 120 * holds_done) begin
        hold_left = HOLD_LEN;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case ((stall_cycle / 40) % 4)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) == 0);
          2:       out_stall <= (stall_cycle % 3 == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic fin, input bit drain);
    byte_req_t item;
    item.req.data_byte = b;
    item.req.is_final  = fin;
    item.drain_first   = drain;
    pending_bytes.push_back(item);
    total_bytes++;
  endtask

  // Stimulus, reset and end of run.
  initial begin
    int unsigned msg_len;
    bit          mid_drain_done;
    mid_drain_done = 0;

    // Directed part: a message ending in each slot, the alphabet edges and '+' and '/'.
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h80, 1'b1, 1'b0);
    push_byte(8'h4D, 1'b0, 1'b0);
    push_byte(8'h61, 1'b0, 1'b0);
    push_byte(8'h6E, 1'b1, 1'b0);
    push_byte(8'hFB, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hBF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hAA, 1'b0, 1'b0);
    push_byte(8'h55, 1'b1, 1'b0);

    // Random messages, mostly short; the first one waits for the directed part to drain,
    // and one in the middle waits again.
    push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    while (total_bytes < RANDOM_TOTAL) begin
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      for (int unsigned i = 0; i < msg_len; i++)
        push_byte(8'($urandom_range(0, 255)), i == msg_len - 1,
                  i == 0 && !mid_drain_done && total_bytes >= 150);
      if (total_bytes >= 150) mid_drain_done = 1;
    end
    push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_bytes != total_bytes || expected_chars.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
